// ===== design/ssd4_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd4_pkg: shared widths, types and step functions
// Widths of the four-sample deviation datapath, plus the per-stage step
// functions of the divide-by-three and square root pipelines.
// ----------------------------------------------------------------------------
package ssd4_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DIFF_W     = SAMPLE_W + 1;     // pairwise difference
	localparam int PROD_W     = 2 * DIFF_W;       // signed product
	localparam int SQ_W       = 2 * SAMPLE_W;     // square of a difference
	localparam int PAIR_SUM_W = SQ_W + 1;
	localparam int QUAD_SUM_W = SQ_W + 2;
	localparam int D_W        = SQ_W + 3;         // 4*sum(x^2) - (sum x)^2
	localparam int NUM_PAIRS  = 6;

	// floor(D / 12) = floor(floor(D / 4) / 3)
	localparam int DIVIDEND_W = D_W - 2;
	localparam int DIV_STEPS  = 9;                // quotient bits per stage
	localparam int DIV_STAGES = 4;
	localparam int DIV_W      = DIV_STEPS * DIV_STAGES;
	localparam int QUOT_W     = 31;               // variance < 2^31

	localparam int ROOT_W     = 16;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SQ_ITERS   = 4;                // root bits per stage
	localparam int SQ_STAGES  = ROOT_W / SQ_ITERS;

	localparam logic [2:0] DIVISOR = 3'd3;

	typedef struct packed {
		logic [1:0]       rem;
		logic [DIV_W-1:0] num;  // dividend bits shift out, quotient bits shift in
	} div3_st_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	// Restoring divide by three, DIV_STEPS bits, MSB first
	function automatic div3_st_t div3_steps(input div3_st_t s_in);
		div3_st_t   s;
		logic [2:0] t;
		s = s_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t     = {s.rem, s.num[DIV_W-1]};
			s.num = {s.num[DIV_W-2:0], 1'b0};
			if (t >= DIVISOR) begin
				s.num[0] = 1'b1;
				s.rem    = 2'(t - DIVISOR);
			end else begin
				s.rem    = t[1:0];
			end
		end
		return s;
	endfunction

	// Digit-by-digit square root, SQ_ITERS root bits
	function automatic sqrt_st_t sqrt_steps(input sqrt_st_t s_in);
		sqrt_st_t         s;
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] trial;
		s = s_in;
		for (int i = 0; i < SQ_ITERS; i++) begin
			r2    = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
			s.rad = {s.rad[RAD_W-3:0], 2'b00};
			trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
			if (r2 >= trial) begin
				s.rem  = r2 - trial;
				s.root = {s.root[ROOT_W-2:0], 1'b1};
			end else begin
				s.rem  = r2;
				s.root = {s.root[ROOT_W-2:0], 1'b0};
			end
		end
		return s;
	endfunction

endpackage

// ===== design/ssd4_div3.sv =====
// ----------------------------------------------------------------------------
// ssd4_div3: pipelined divide by three
// Restoring long division, DIV_STEPS quotient bits per register stage.
// ----------------------------------------------------------------------------
module ssd4_div3 import ssd4_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DIVIDEND_W-1:0] dividend,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [QUOT_W-1:0]     quotient
);

	logic [DIV_STAGES-1:0] vld_s;
	div3_st_t              st_s  [DIV_STAGES];
	div3_st_t              nxt   [DIV_STAGES];
	logic [DIV_STAGES-1:0] vin;
	logic [DIV_STAGES:0]   en;
	div3_st_t              init;

	assign init.rem = 2'b00;
	assign init.num = {{(DIV_W-DIVIDEND_W){1'b0}}, dividend};

	always_comb begin
		en[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en[k] = ~vld_s[k] | en[k+1];
		end
		vin[0] = in_valid;
		nxt[0] = div3_steps(init);
		for (int k = 1; k < DIV_STAGES; k++) begin
			vin[k] = vld_s[k-1];
			nxt[k] = div3_steps(st_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vin[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en[k] && vin[k]) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[DIV_STAGES-1];
	assign quotient  = st_s[DIV_STAGES-1].num[QUOT_W-1:0];

endmodule

// ===== design/ssd4_isqrt.sv =====
// ----------------------------------------------------------------------------
// ssd4_isqrt: pipelined integer square root
// Floor square root, SQ_ITERS result bits per register stage.
// ----------------------------------------------------------------------------
module ssd4_isqrt import ssd4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [QUOT_W-1:0] radicand,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_STAGES-1:0] vld_s;
	sqrt_st_t             st_s  [SQ_STAGES];
	sqrt_st_t             nxt   [SQ_STAGES];
	logic [SQ_STAGES-1:0] vin;
	logic [SQ_STAGES:0]   en;
	sqrt_st_t             init;

	assign init.rad  = {{(RAD_W-QUOT_W){1'b0}}, radicand};
	assign init.rem  = '0;
	assign init.root = '0;

	always_comb begin
		en[SQ_STAGES] = out_ready;
		for (int k = SQ_STAGES - 1; k >= 0; k--) begin
			en[k] = ~vld_s[k] | en[k+1];
		end
		vin[0] = in_valid;
		nxt[0] = sqrt_steps(init);
		for (int k = 1; k < SQ_STAGES; k++) begin
			vin[k] = vld_s[k-1];
			nxt[k] = sqrt_steps(st_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vin[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (en[k] && vin[k]) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[SQ_STAGES-1];
	assign root      = st_s[SQ_STAGES-1].root;

endmodule

// ===== design/sample_std_dev_of_four.sv =====
// ----------------------------------------------------------------------------
// sample_std_dev_of_four: sample standard deviation of four samples
// Exact integer pipeline: floor(sqrt(floor((4*sum(x^2) - (sum x)^2) / 12))).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_ready carries four signed 16-bit samples
//   (sample_a..sample_d). Output channel out_valid / out_ready carries the
//   unsigned 16-bit deviation, in the samples' fixed-point scale.
//   Throughput: one transfer per cycle on each side, sustained while out_ready stays high.
//   Stages in order: s1 differences, s2 squares, s3..s5 the adder tree,
//     then the divide-by-three pipeline (9 quotient bits per stage),
//     then the square root pipeline (4 root bits per stage).
//   The last square root stage is the output register.
//   Every stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and in_ready stays high while
//   a finished result waits, until every stage holds an item.
//   A receiver stall holds all full stages in place; nothing is lost or
//   repeated. Reset clears only the valid bits; no item state survives it.
// ----------------------------------------------------------------------------
module sample_std_dev_of_four import ssd4_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_a,
	input  logic signed [SAMPLE_W-1:0] sample_b,
	input  logic signed [SAMPLE_W-1:0] sample_c,
	input  logic signed [SAMPLE_W-1:0] sample_d,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ROOT_W-1:0]          deviation
);

	// 4*sum(x^2) - (sum x)^2 equals the sum of the six squared pairwise
	// differences, which keeps every term non-negative and 32 bits wide.

	logic v1_s, v2_s, v3_s, v4_s, v5_s;
	logic en1, en2, en3, en4, en5;
	logic div_in_ready, div_out_valid, sqrt_in_ready;
	logic [QUOT_W-1:0] quot;

	logic signed [DIFF_W-1:0] diff_s1 [NUM_PAIRS];
	logic [SQ_W-1:0]          sq_s2   [NUM_PAIRS];
	logic [PAIR_SUM_W-1:0]    pair_s3 [3];
	logic [QUAD_SUM_W-1:0]    quad_s4;
	logic [PAIR_SUM_W-1:0]    rest_s4;
	logic [D_W-1:0]           d_s5;

	logic signed [DIFF_W-1:0] xa, xb, xc, xd;
	logic signed [PROD_W-1:0] prod [NUM_PAIRS];

	// Sign-extend so a difference never wraps
	assign xa = DIFF_W'(sample_a);
	assign xb = DIFF_W'(sample_b);
	assign xc = DIFF_W'(sample_c);
	assign xd = DIFF_W'(sample_d);

	always_comb begin
		for (int p = 0; p < NUM_PAIRS; p++) begin
			prod[p] = PROD_W'(diff_s1[p]) * PROD_W'(diff_s1[p]);
		end
	end

	// Stage enables: a stage loads when empty or when its successor moves
	assign en5      = ~v5_s | div_in_ready;
	assign en4      = ~v4_s | en5;
	assign en3      = ~v3_s | en4;
	assign en2      = ~v2_s | en3;
	assign en1      = ~v1_s | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
			v4_s <= 1'b0;
			v5_s <= 1'b0;
		end else begin
			if (en1) v1_s <= in_valid;
			if (en2) v2_s <= v1_s;
			if (en3) v3_s <= v2_s;
			if (en4) v4_s <= v3_s;
			if (en5) v5_s <= v4_s;
		end
	end

	always_ff @(posedge clk) begin
		// s1: pairwise differences
		if (en1 && in_valid) begin
			diff_s1[0] <= xa - xb;
			diff_s1[1] <= xa - xc;
			diff_s1[2] <= xa - xd;
			diff_s1[3] <= xb - xc;
			diff_s1[4] <= xb - xd;
			diff_s1[5] <= xc - xd;
		end
		// s2: squares, |diff| <= 65535 so each fits 32 bits
		if (en2 && v1_s) begin
			for (int p = 0; p < NUM_PAIRS; p++) begin
				sq_s2[p] <= prod[p][SQ_W-1:0];
			end
		end
		// s3..s5: adder tree
		if (en3 && v2_s) begin
			for (int j = 0; j < 3; j++) begin
				pair_s3[j] <= PAIR_SUM_W'(sq_s2[2*j]) + PAIR_SUM_W'(sq_s2[2*j+1]);
			end
		end
		if (en4 && v3_s) begin
			quad_s4 <= QUAD_SUM_W'(pair_s3[0]) + QUAD_SUM_W'(pair_s3[1]);
			rest_s4 <= pair_s3[2];
		end
		if (en5 && v4_s) begin
			d_s5 <= D_W'(quad_s4) + D_W'(rest_s4);
		end
	end

	// floor(D/12): drop two bits, then divide by three
	ssd4_div3 u_div3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v5_s),
		.in_ready  (div_in_ready),
		.dividend  (d_s5[D_W-1:2]),
		.out_valid (div_out_valid),
		.out_ready (sqrt_in_ready),
		.quotient  (quot)
	);

	ssd4_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_out_valid),
		.in_ready  (sqrt_in_ready),
		.radicand  (quot),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.root      (deviation)
	);

endmodule
